// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the sorted priority queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== src/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes shared by the sorted priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_SERVED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               command;
        logic signed [31:0] entry_id;
        logic signed [15:0] urgency;
    } req_item_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] served_id;
    } rsp_item_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SERVE  = 2'd2
    } cell_op_t;

    // Broadcast to every cell
    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] new_id;
        logic signed [15:0] new_urg;
    } cell_ctrl_t;

    // What a cell shows its neighbours
    typedef struct packed {
        logic               valid;
        logic               stays;
        logic signed [31:0] id;
        logic signed [15:0] urg;
    } cell_state_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: keeps, takes the new item, or shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  spq_pkg::cell_state_t left,
    input  spq_pkg::cell_state_t right,
    output spq_pkg::cell_state_t state
);
    import spq_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] id_reg;
    logic signed [31:0] id_next;
    logic signed [15:0] urg_reg;
    logic signed [15:0] urg_next;
    logic               stays;

    // Equal urgency stays ahead: FIFO among ties
    assign stays = valid_reg && (urg_reg >= ctrl.new_urg);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        urg_next   = urg_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                valid_next = valid_reg | left.valid;
                if (!stays)
                begin
                    if (left.stays)
                    begin
                        id_next  = ctrl.new_id;
                        urg_next = ctrl.new_urg;
                    end
                    else
                    begin
                        id_next  = left.id;
                        urg_next = left.urg;
                    end
                end
            end
            OP_SERVE:
            begin
                valid_next = right.valid;
                id_next    = right.id;
                urg_next   = right.urg;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        urg_reg <= urg_next;
    end

    assign state.valid = valid_reg;
    assign state.stays = stays;
    assign state.id    = id_reg;
    assign state.urg   = urg_reg;

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
// ---------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded max-priority queue held sorted in a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------
//  request   | start, busy, request   | taken when start && !busy
//  response  | done, response         | one-cycle strobe, no stall
//
//  One item per cycle: every cell compares and shifts in the accept cycle,
//  the response appears the cycle after. busy stays low.
//  Reset clears the cell valid bits (empty queue) and the response strobe;
//  slot contents are left unset. Responses cannot be held off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  spq_pkg::req_item_t  request,
    output logic                done,
    output spq_pkg::rsp_item_t  response
);
    import spq_pkg::*;

    cell_state_t cells [DEPTH];
    cell_state_t head_left;
    cell_state_t tail_right;
    cell_ctrl_t  ctrl;

    logic      accept;
    logic      full;
    logic      empty;
    logic      done_reg;
    logic      done_next;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = cells[DEPTH-1].valid;
    assign empty  = !cells[0].valid;

    assign head_left  = '{valid: 1'b1, stays: 1'b1, id: '0, urg: '0};
    assign tail_right = '{valid: 1'b0, stays: 1'b0, id: '0, urg: '0};

    always_comb
    begin
        ctrl.op      = OP_HOLD;
        ctrl.new_id  = request.entry_id;
        ctrl.new_urg = request.urgency;
        rsp_next     = rsp_reg;
        done_next    = accept;
        if (accept)
        begin
            rsp_next.served_id = '0;
            if (request.command == CMD_INSERT)
            begin
                if (full)
                begin
                    rsp_next.status = ST_DROPPED;
                end
                else
                begin
                    rsp_next.status = ST_INSERTED;
                    ctrl.op         = OP_INSERT;
                end
            end
            else
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.status    = ST_SERVED;
                    rsp_next.served_id = cells[0].id;
                    ctrl.op            = OP_SERVE;
                end
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_state_t left_in;
        cell_state_t right_in;
        if (i == 0)
        begin : g_head
            assign left_in = head_left;
        end
        else
        begin : g_left
            assign left_in = cells[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_in = tail_right;
        end
        else
        begin : g_right
            assign right_in = cells[i+1];
        end
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_in),
            .right (right_in),
            .state (cells[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    // valid bits form a thermometer from the head
    for (genvar j = 0; j < DEPTH - 1; j++)
    begin : g_chk
        `ASSERT_CLK(a_thermo, clk, rst_n, cells[j+1].valid |-> cells[j].valid)
    end

    `ASSERT_CLK(a_done_follows, clk, rst_n, accept |=> done)
    `ASSERT_CLK(a_no_spurious, clk, rst_n, !accept |=> !done)
    `ASSERT_CLK(a_serve_nonempty, clk, rst_n, (done && response.status == ST_SERVED) |-> $past(!empty))
    `ASSERT_CLK(a_drop_full, clk, rst_n, (done && response.status == ST_DROPPED) |-> $past(full))

endmodule

`default_nettype wire

// ===== sim/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and response channels of the sorted priority queue,
// keeps its own sorted copy of the queue contents and compares every
// response, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire        busy,
    input  req_item_t  request,
    input  wire        done,
    input  rsp_item_t  response,
    output int         errors,
    output int         pending
);

    logic signed [31:0] held_id  [DEPTH];
    logic signed [15:0] held_urg [DEPTH];
    int                 held_count;
    rsp_item_t          due_rsp [$];

    // Sorted insert behind equal urgencies, serve from the head
    function automatic rsp_item_t queue_outcome(input req_item_t it);
        rsp_item_t r;
        int        pos;
        r.status    = ST_INSERTED;
        r.served_id = '0;
        if (it.command == CMD_INSERT)
        begin
            if (held_count >= DEPTH)
            begin
                r.status = ST_DROPPED;
            end
            else
            begin
                pos = 0;
                while (pos < held_count && held_urg[pos] >= it.urgency)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_id[i]  = held_id[i-1];
                    held_urg[i] = held_urg[i-1];
                end
                held_id[pos]  = it.entry_id;
                held_urg[pos] = it.urgency;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.status    = ST_SERVED;
            r.served_id = held_id[0];
            for (int i = 0; i + 1 < held_count; i++)
            begin
                held_id[i]  = held_id[i+1];
                held_urg[i] = held_urg[i+1];
            end
            held_count--;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (errors < 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            held_count = 0;
            due_rsp.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_rsp.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected response, status %0d id %h", $time,
                                 response.status, response.served_id);
                    errors++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (response.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(response.status));
                    if (response.served_id !== want.served_id)
                        note_mismatch("served_id", want.served_id, response.served_id);
                end
            end
            if (start && !busy)
                due_rsp.push_back(queue_outcome(request));
            pending <= due_rsp.size();
        end
    end

endmodule

// ===== sim/sorted_priority_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Drives insert and serve items into the sorted priority queue: a directed
// run over the extremes, ties, empty serves and ignored fields, then random
// fill, drain and mixed phases that reach the full queue many times over,
// with random idle gaps. Responses are checked by spq_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int N_ITEMS = 1150;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    req_item_t request;
    logic      done;
    rsp_item_t response;
    int        errors;
    int        pending;
    int        sent;
    bit        calm;

    sorted_priority_queue_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    spq_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic req_item_t mk(input logic cmd, input logic [31:0] id,
                                     input logic [15:0] urg);
        req_item_t it;
        it.command  = cmd;
        it.entry_id = id;
        it.urgency  = urg;
        return it;
    endfunction

    // Largely narrow or extreme urgencies so that ties are common
    function automatic req_item_t random_item(input int insert_pct);
        int        r;
        logic [15:0] urg;
        r = $urandom_range(0, 9);
        if (r < 4)
            urg = 16'($signed($urandom_range(0, 4)) - 2);
        else if (r < 8)
            urg = 16'($urandom);
        else if (r == 8)
            urg = 16'h7fff;
        else
            urg = 16'h8000;
        return mk(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_SERVE,
                  $urandom, urg);
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input req_item_t it);
        int gap;
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  pct;
        int  len;
        bit  paused;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        sent    = 0;
        calm    = 1'b0;
        paused  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk(CMD_SERVE,  32'h0000_0000, 16'h0000));
        send_item(mk(CMD_INSERT, 32'h7fff_ffff, 16'h7fff));
        send_item(mk(CMD_INSERT, 32'h8000_0000, 16'h8000));
        send_item(mk(CMD_INSERT, 32'h0000_0000, 16'h0000));
        send_item(mk(CMD_INSERT, 32'hffff_ffff, 16'h0000));
        send_item(mk(CMD_INSERT, 32'h0000_0001, 16'h0000));
        send_item(mk(CMD_INSERT, 32'h0001_2345, 16'h7fff));
        send_item(mk(CMD_INSERT, 32'h0000_0055, 16'h8000));
        send_item(mk(CMD_INSERT, 32'h5555_aaaa, 16'hffff));
        send_item(mk(CMD_INSERT, 32'haaaa_5555, 16'h0001));
        for (int i = 0; i < 10; i++)
            send_item(mk(CMD_SERVE, $urandom, 16'($urandom)));
        send_item(mk(CMD_SERVE, 32'hffff_ffff, 16'hffff));
        wait_quiet();

        // Opening phase fills the queue past full
        pct = 100;
        len = 72;
        while (sent < N_ITEMS)
        begin
            for (int i = 0; i < len && sent < N_ITEMS; i++)
                send_item(random_item(pct));
            if (!paused && sent >= 600)
            begin
                wait_quiet();
                paused = 1'b1;
            end
            case ($urandom_range(0, 3))
                0:       pct = 90;
                1:       pct = 10;
                2:       pct = 50;
                default: pct = 70;
            endcase
            len  = $urandom_range(20, 150);
            calm = ($urandom_range(0, 3) == 0);
        end

        wait_quiet();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_top.f =====
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
sim/spq_checker.sv
sim/sorted_priority_queue_top_tb.sv
